@@ sv/lupf_pkg.sv @@
`default_nettype none

package lupf_pkg;

  // Field and counter widths.
  localparam int COORD_W = 24;
  localparam int IDX_W   = 18;
  localparam int CFG_W   = 13;
  localparam int COL_W   = 12;
  localparam int ROW_W   = 6;

  // Row geometry limits and the judged window of columns.
  localparam logic [CFG_W-1:0] MAX_ROW_WIDTH = 13'd4096;
  localparam logic [CFG_W-1:0] MIN_ROW_WIDTH = 13'd1;
  localparam logic [COL_W-1:0] FIRST_JUDGED  = 12'd6;
  localparam logic [CFG_W-1:0] TAIL_MARGIN   = 13'd5;

  // Arithmetic widths: one multiplier lane, one digit of the wide products,
  // squared distances, squared ranges and the wide gap-test products.
  localparam int LANE_W  = 26;
  localparam int PROD_W  = 2 * LANE_W;
  localparam int CHUNK_W = 24;
  localparam int DIST_W  = 50;
  localparam int NORM_W  = 48;
  localparam int N1C_W   = 64;
  localparam int D200_W  = 56;
  localparam int WIDE_W  = 112;

  // Gap test constants: 39601 * n1 * n2 < (200 * dot)^2.
  localparam logic signed [LANE_W-1:0] GAP_NEAR = 26'sd39601;
  localparam logic signed [LANE_W-1:0] GAP_FAR  = 26'sd200;

  // Occluded run length and the offset of its start on the far side.
  localparam logic [2:0] OCCL_RUN  = 3'd6;
  localparam logic [2:0] OCCL_BACK = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0] idx_t;

  // One judged column: next point, judged point, previous point, flat index.
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t ix;
    coord_t iy;
    coord_t iz;
    coord_t mx;
    coord_t my;
    coord_t mz;
    idx_t   base;
  } job_t;

  // Outcome of both tests for one judged column.
  typedef struct packed {
    logic occl;
    logic far_side;
    logic par;
    idx_t base;
  } verdict_t;

  typedef struct packed {
    idx_t index;
    logic last;
  } res_t;

endpackage

`default_nettype wire

@@ sv/lupf_front.sv @@
`default_nettype none

module lupf_front import lupf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire coord_t           point_x_i,
  input  wire coord_t           point_y_i,
  input  wire coord_t           point_z_i,
  input  wire logic             start_of_cloud_i,
  output logic                  job_valid_o,
  output job_t                  job_o,
  input  wire logic             job_ready_i
);

  logic [CFG_W-1:0] row_width_q;
  logic [CFG_W-1:0] w_eff;
  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [CFG_W-1:0] col_inc;
  logic [IDX_W:0]   base_full;
  logic             judge;
  logic             accept;
  coord_t           h0x_q, h0y_q, h0z_q, h1x_q, h1y_q, h1z_q;

  job_t       jq_q [2];
  logic [1:0] cnt_q;
  logic       wr_q, rd_q;
  logic       push_j, pop_j;

  // Width register, clamped to the supported range where it is used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= MAX_ROW_WIDTH;
    end else if (cfg_we_i) begin
      row_width_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (row_width_q < MIN_ROW_WIDTH) begin
      w_eff = MIN_ROW_WIDTH;
    end else if (row_width_q > MAX_ROW_WIDTH) begin
      w_eff = MAX_ROW_WIDTH;
    end else begin
      w_eff = row_width_q;
    end
  end

  // Position of the arriving point and the judgment of the column before it.
  assign col_cur   = start_of_cloud_i ? '0 : col_q;
  assign row_cur   = start_of_cloud_i ? '0 : row_q;
  assign judge     = (col_cur >= FIRST_JUDGED) && ({1'b0, col_cur} + TAIL_MARGIN < w_eff);
  assign base_full = (IDX_W+1)'(row_cur) * (IDX_W+1)'(w_eff) + (IDX_W+1)'(col_cur)
                     - (IDX_W+1)'(1);
  assign col_inc   = {1'b0, col_cur} + CFG_W'(1);

  always_comb begin
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = row_cur + ROW_W'(1);
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = row_cur;
    end
  end

  assign accept = push_i && !full_o;
  assign push_j = accept && judge;
  assign pop_j  = job_valid_o && job_ready_i;

  // Counters and the two held points of the row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      h0x_q <= '0;
      h0y_q <= '0;
      h0z_q <= '0;
      h1x_q <= '0;
      h1y_q <= '0;
      h1z_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      h1x_q <= h0x_q;
      h1y_q <= h0y_q;
      h1z_q <= h0z_q;
      h0x_q <= point_x_i;
      h0y_q <= point_y_i;
      h0z_q <= point_z_i;
    end
  end

  // Two-entry job queue toward the arithmetic unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(push_j) - 2'(pop_j);
      if (push_j) begin
        wr_q <= ~wr_q;
      end
      if (pop_j) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_j) begin
      jq_q[wr_q] <= '{cx: point_x_i, cy: point_y_i, cz: point_z_i,
                      ix: h0x_q, iy: h0y_q, iz: h0z_q,
                      mx: h1x_q, my: h1y_q, mz: h1z_q,
                      base: base_full[IDX_W-1:0]};
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = jq_q[rd_q];

endmodule

`default_nettype wire

@@ sv/lupf_arith.sv @@
`default_nettype none

module lupf_arith import lupf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output logic      job_ready_o,
  output logic      verdict_valid_o,
  output verdict_t  verdict_o,
  input  wire logic verdict_ready_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_CHK, ST_CMP, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_DIFF, OP_DIFF2, OP_N1, OP_N2, OP_DOT,
    OP_N1C, OP_A0, OP_A1, OP_D200, OP_B0, OP_B1, OP_B2
  } op_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   need_q, need_d, far_q, far_d, par_q, par_d, occl_q, occl_d;

  job_t                     job_q, job_d;
  logic signed [PROD_W-1:0] p_q [3];
  logic signed [PROD_W-1:0] p_d [3];
  logic [DIST_W-1:0]        diff_q, diff_d, diff2_q, diff2_d;
  logic [NORM_W-1:0]        n1_q, n1_d, n2_q, n2_d;
  logic signed [DIST_W-1:0] dot_q, dot_d;
  logic [N1C_W-1:0]         n1c_q, n1c_d;
  logic [D200_W-1:0]        d200_q, d200_d;
  logic [WIDE_W-1:0]        pa_q, pa_d, pb_q, pb_d;

  coord_t                   cur [3];
  coord_t                   pi  [3];
  coord_t                   pm  [3];
  logic signed [LANE_W-1:0] a   [3];
  logic signed [LANE_W-1:0] b   [3];
  logic signed [PROD_W+1:0] sum3;
  logic [WIDE_W-1:0]        rowsum;
  logic [DIST_W+4:0]        diff20;
  logic [DIST_W+12:0]       diff64, diff2_64;

  assign cur[0] = job_q.cx;
  assign cur[1] = job_q.cy;
  assign cur[2] = job_q.cz;
  assign pi[0]  = job_q.ix;
  assign pi[1]  = job_q.iy;
  assign pi[2]  = job_q.iz;
  assign pm[0]  = job_q.mx;
  assign pm[1]  = job_q.my;
  assign pm[2]  = job_q.mz;

  // Operand selection for the three multiplier lanes.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a[k] = '0;
      b[k] = '0;
    end
    unique case (op_q)
      OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          a[k] = LANE_W'(cur[k]) - LANE_W'(pi[k]);
          b[k] = a[k];
        end
      end
      OP_DIFF2: begin
        for (int k = 0; k < 3; k++) begin
          a[k] = LANE_W'(pi[k]) - LANE_W'(pm[k]);
          b[k] = a[k];
        end
      end
      OP_N1: begin
        for (int k = 0; k < 3; k++) begin
          a[k] = LANE_W'(pi[k]);
          b[k] = LANE_W'(pi[k]);
        end
      end
      OP_N2: begin
        for (int k = 0; k < 3; k++) begin
          a[k] = LANE_W'(cur[k]);
          b[k] = LANE_W'(cur[k]);
        end
      end
      OP_DOT: begin
        for (int k = 0; k < 3; k++) begin
          a[k] = LANE_W'(pi[k]);
          b[k] = LANE_W'(cur[k]);
        end
      end
      OP_N1C: begin
        a[0] = {2'b00, n1_q[CHUNK_W-1:0]};
        a[1] = {2'b00, n1_q[2*CHUNK_W-1:CHUNK_W]};
        b[0] = GAP_NEAR;
        b[1] = GAP_NEAR;
      end
      OP_A0, OP_A1: begin
        a[0] = {2'b00, n1c_q[CHUNK_W-1:0]};
        a[1] = {2'b00, n1c_q[2*CHUNK_W-1:CHUNK_W]};
        a[2] = LANE_W'(n1c_q[N1C_W-1:2*CHUNK_W]);
        for (int k = 0; k < 3; k++) begin
          b[k] = (op_q == OP_A0) ? {2'b00, n2_q[CHUNK_W-1:0]}
                                 : {2'b00, n2_q[2*CHUNK_W-1:CHUNK_W]};
        end
      end
      OP_D200: begin
        a[0] = {2'b00, dot_q[CHUNK_W-1:0]};
        a[1] = {2'b00, dot_q[2*CHUNK_W-1:CHUNK_W]};
        b[0] = GAP_FAR;
        b[1] = GAP_FAR;
      end
      OP_B0, OP_B1, OP_B2: begin
        a[0] = {2'b00, d200_q[CHUNK_W-1:0]};
        a[1] = {2'b00, d200_q[2*CHUNK_W-1:CHUNK_W]};
        a[2] = LANE_W'(d200_q[D200_W-1:2*CHUNK_W]);
        for (int k = 0; k < 3; k++) begin
          if (op_q == OP_B0) begin
            b[k] = {2'b00, d200_q[CHUNK_W-1:0]};
          end else if (op_q == OP_B1) begin
            b[k] = {2'b00, d200_q[2*CHUNK_W-1:CHUNK_W]};
          end else begin
            b[k] = LANE_W'(d200_q[D200_W-1:2*CHUNK_W]);
          end
        end
      end
      default: begin
        a[0] = '0;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_d[k] = a[k] * b[k];
    end
  end

  // Reductions of the registered lane products.
  assign sum3   = (PROD_W+2)'(p_q[0]) + (PROD_W+2)'(p_q[1]) + (PROD_W+2)'(p_q[2]);
  assign rowsum = WIDE_W'(p_q[0][2*CHUNK_W-1:0])
                + (WIDE_W'(p_q[1][2*CHUNK_W-1:0]) << CHUNK_W)
                + (WIDE_W'(p_q[2][2*CHUNK_W-1:0]) << (2*CHUNK_W));

  assign diff20   = (DIST_W+5)'(diff_q) * (DIST_W+5)'(20);
  assign diff64   = (DIST_W+13)'(diff_q) * (DIST_W+13)'(6400);
  assign diff2_64 = (DIST_W+13)'(diff2_q) * (DIST_W+13)'(6400);

  // Sequencer: one multiply step and one accumulate step per operation.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    need_d  = need_q;
    far_d   = far_q;
    par_d   = par_q;
    occl_d  = occl_q;
    job_d   = job_q;
    diff_d  = diff_q;
    diff2_d = diff2_q;
    n1_d    = n1_q;
    n2_d    = n2_q;
    dot_d   = dot_q;
    n1c_d   = n1c_q;
    d200_d  = d200_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    job_ready_o     = 1'b0;
    verdict_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          job_d   = job_i;
          op_d    = OP_DIFF;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = ST_MUL;
        unique case (op_q)
          OP_DIFF: begin
            diff_d = sum3[DIST_W-1:0];
            op_d   = OP_DIFF2;
          end
          OP_DIFF2: begin
            diff2_d = sum3[DIST_W-1:0];
            op_d    = OP_N1;
          end
          OP_N1: begin
            n1_d = sum3[NORM_W-1:0];
            op_d = OP_N2;
          end
          OP_N2: begin
            n2_d = sum3[NORM_W-1:0];
            op_d = OP_DOT;
          end
          OP_DOT: begin
            dot_d   = $signed(sum3[DIST_W-1:0]);
            state_d = ST_CHK;
          end
          OP_N1C: begin
            n1c_d = rowsum[N1C_W-1:0];
            op_d  = OP_A0;
          end
          OP_A0: begin
            pa_d = rowsum;
            op_d = OP_A1;
          end
          OP_A1: begin
            pa_d = pa_q + (rowsum << CHUNK_W);
            op_d = OP_D200;
          end
          OP_D200: begin
            d200_d = rowsum[D200_W-1:0];
            op_d   = OP_B0;
          end
          OP_B0: begin
            pb_d = rowsum;
            op_d = OP_B1;
          end
          OP_B1: begin
            pb_d = pb_q + (rowsum << CHUNK_W);
            op_d = OP_B2;
          end
          OP_B2: begin
            pb_d    = pb_q + (rowsum << (2*CHUNK_W));
            state_d = ST_CMP;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_CHK: begin
        // Large jump toward a point in the same half-space starts the gap test.
        need_d = (diff20 > ((DIST_W+5)'(1) << 32)) && !dot_q[DIST_W-1] && (dot_q != '0);
        par_d  = (diff64 > (DIST_W+13)'(n1_q)) && (diff2_64 > (DIST_W+13)'(n1_q));
        far_d  = (n1_q > n2_q);
        if (need_d) begin
          op_d    = OP_N1C;
          state_d = ST_MUL;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        occl_d  = need_q && (pa_q < pb_q);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        verdict_valid_o = 1'b1;
        if (verdict_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign verdict_o = '{occl: occl_q, far_side: far_q, par: par_q, base: job_q.base};

  // State and verdict flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_DIFF;
      need_q  <= 1'b0;
      far_q   <= 1'b0;
      par_q   <= 1'b0;
      occl_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      need_q  <= need_d;
      far_q   <= far_d;
      par_q   <= par_d;
      occl_q  <= occl_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    p_q     <= p_d;
    diff_q  <= diff_d;
    diff2_q <= diff2_d;
    n1_q    <= n1_d;
    n2_q    <= n2_d;
    dot_q   <= dot_d;
    n1c_q   <= n1c_d;
    d200_q  <= d200_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
  end

endmodule

`default_nettype wire

@@ sv/lupf_emit.sv @@
`default_nettype none

module lupf_emit import lupf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     verdict_valid_i,
  input  wire verdict_t verdict_i,
  output logic          verdict_ready_o,
  output logic          empty_o,
  input  wire logic     pop_i,
  output idx_t          point_index_o,
  output logic          is_last_o
);

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  localparam int RES_DEPTH = 8;
  localparam int PTR_W     = $clog2(RES_DEPTH);

  state_e     state_q;
  verdict_t   v_q;
  logic [2:0] k_q;
  res_t       cur_res;
  logic       res_push, res_pop, res_full;
  logic       take;

  res_t             mem_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;

  // Current result of the running verdict: the occluded run, then the judged point.
  always_comb begin
    if (k_q < OCCL_RUN) begin
      cur_res.index = v_q.far_side ? v_q.base - IDX_W'(OCCL_BACK) + IDX_W'(k_q)
                                   : v_q.base + IDX_W'(1) + IDX_W'(k_q);
      cur_res.last  = (k_q == OCCL_RUN - 3'd1) && !v_q.par;
    end else begin
      cur_res.index = v_q.base;
      cur_res.last  = 1'b1;
    end
  end

  assign verdict_ready_o = (state_q == ST_IDLE);
  assign take            = verdict_valid_i && verdict_ready_o && (verdict_i.occl || verdict_i.par);
  assign res_full        = (cnt_q == (PTR_W+1)'(RES_DEPTH));
  assign res_push        = (state_q == ST_RUN) && !res_full;
  assign res_pop         = pop_i && !empty_o;

  // Result sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            state_q <= ST_RUN;
            k_q     <= verdict_i.occl ? 3'd0 : OCCL_RUN;
          end
        end
        ST_RUN: begin
          if (res_push) begin
            if (cur_res.last) begin
              state_q <= ST_IDLE;
            end else begin
              k_q <= k_q + 3'd1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      v_q <= verdict_i;
    end
  end

  // Result queue; each beat leaves from its head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + (PTR_W+1)'(res_push) - (PTR_W+1)'(res_pop);
      if (res_push) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (res_pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      mem_q[wr_q] <= cur_res;
    end
  end

  assign empty_o       = (cnt_q == '0);
  assign point_index_o = mem_q[rd_q].index;
  assign is_last_o     = mem_q[rd_q].last;

endmodule

`default_nettype wire

@@ sv/lidar_unreliable_point_filter.sv @@
// Path: a judged point goes through the job queue, the range and jump tests, the occlusion
// gap test when it runs, and the result sequencer. Throughput: one point per cycle while
// the job queue is not full; a judged point holds the shared three-lane multiplier until
// its verdict is taken, and its up to seven indices leave one a cycle while the queue has room.
// Reset: asynchronous, active low; it empties both queues, clears the held points and the
// row and column counts, and sets the row width to 4096.
`default_nettype none

module lidar_unreliable_point_filter import lupf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             row_width_we_i,
  input  wire logic [CFG_W-1:0] row_width_i,
  input  wire logic             push,
  output logic                  full,
  input  wire coord_t           point_x_i,
  input  wire coord_t           point_y_i,
  input  wire coord_t           point_z_i,
  input  wire logic             start_of_cloud_i,
  output logic                  empty,
  input  wire logic             pop,
  output idx_t                  point_index_o,
  output logic                  is_last_o
);

  logic     job_valid, job_ready;
  job_t     job;
  logic     verdict_valid, verdict_ready;
  verdict_t verdict;

  lupf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (row_width_we_i),
    .cfg_data_i       (row_width_i),
    .push_i           (push),
    .full_o           (full),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .point_z_i        (point_z_i),
    .start_of_cloud_i (start_of_cloud_i),
    .job_valid_o      (job_valid),
    .job_o            (job),
    .job_ready_i      (job_ready)
  );

  lupf_arith u_arith (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (job),
    .job_ready_o     (job_ready),
    .verdict_valid_o (verdict_valid),
    .verdict_o       (verdict),
    .verdict_ready_i (verdict_ready)
  );

  lupf_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .verdict_valid_i (verdict_valid),
    .verdict_i       (verdict),
    .verdict_ready_o (verdict_ready),
    .empty_o         (empty),
    .pop_i           (pop),
    .point_index_o   (point_index_o),
    .is_last_o       (is_last_o)
  );

  // The arithmetic unit is busy in the cycle after it takes a job.
  a_job_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && job_ready |=> !job_ready)
    else $error("arith unit took a second job back to back");

  // A verdict that produces indices keeps the sequencer busy on the next cycle.
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_valid && verdict_ready && (verdict.occl || verdict.par) |=> !verdict_ready)
    else $error("result sequencer did not start on a verdict");

  // A verdict is only offered after the unit has worked on a job.
  a_verdict_after_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(verdict_valid) |-> !job_ready)
    else $error("verdict offered while the arith unit was idle");

endmodule

`default_nettype wire

@@ sim/lidar_unreliable_point_filter_test.sv @@
`timescale 1ns / 1ps

module lidar_unreliable_point_filter_test;
  import lupf_pkg::*;

  // Flags every point the filter marks as unreliable, predicted per input beat.
  class index_board;
    res_t        pending_idx[$];
    int          errors;
    int unsigned width_reg;
    longint      hx[2], hy[2], hz[2];
    int unsigned col_cnt, row_cnt;

    function new();
      width_reg = 4096;
      hx = '{0, 0}; hy = '{0, 0}; hz = '{0, 0};
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
    endfunction

    function automatic longint sq3(longint a, longint b, longint c);
      return a * a + b * b + c * c;
    endfunction

    function automatic int pending();
      return pending_idx.size();
    endfunction

    task automatic report(string what, int unsigned got, int unsigned want);
      $display("error: %s got %0d expected %0d", what, got, want);
      errors++;
    endtask

    // Judges the held column when the next point arrives, then shifts the window.
    function automatic void note_point(coord_t x, coord_t y, coord_t z, logic sof);
      longint cx, cy, cz, ix, iy, iz, mx, my, mz;
      longint jump_next, jump_prev, n1, n2, dot, base;
      logic [127:0] lhs, rhs, a, b;
      int unsigned w;
      int first;
      res_t r;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > 4096) w = 4096;
      cx = longint'(x); cy = longint'(y); cz = longint'(z);
      if (sof) begin
        row_cnt = 0;
        col_cnt = 0;
      end
      first = pending_idx.size();
      if (col_cnt >= 6 && col_cnt + 5 < w) begin
        ix = hx[0]; iy = hy[0]; iz = hz[0];
        mx = hx[1]; my = hy[1]; mz = hz[1];
        base = longint'(row_cnt) * w + col_cnt - 1;
        jump_next = sq3(cx - ix, cy - iy, cz - iz);
        jump_prev = sq3(ix - mx, iy - my, iz - mz);
        n1 = sq3(ix, iy, iz);
        n2 = sq3(cx, cy, cz);
        // Occlusion: a large jump between two nearly collinear beams.
        if (jump_next * 20 > (64'sd1 <<< 32)) begin
          dot = ix * cx + iy * cy + iz * cz;
          if (dot > 0) begin
            a = 128'(n1 * 39601);
            b = 128'(n2);
            lhs = a * b;
            a = 128'(dot * 200);
            rhs = a * a;
            if (lhs < rhs) begin
              for (int k = 0; k < 6; k++) begin
                r.index = (n1 > n2) ? idx_t'(base - 5 + k) : idx_t'(base + 1 + k);
                r.last = 1'b0;
                pending_idx = {pending_idx, r};
              end
            end
          end
        end
        // Parallel beam: both neighbor jumps large against the range.
        if (jump_next * 6400 > n1 && jump_prev * 6400 > n1) begin
          r.index = idx_t'(base);
          r.last = 1'b0;
          pending_idx = {pending_idx, r};
        end
        if (pending_idx.size() > first) pending_idx[pending_idx.size() - 1].last = 1'b1;
      end
      hx[1] = hx[0]; hy[1] = hy[0]; hz[1] = hz[0];
      hx[0] = cx; hy[0] = cy; hz[0] = cz;
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1) % 64;
      end
    endfunction

    task automatic check_index(idx_t got_idx, logic got_last);
      res_t want;
      if (pending_idx.size() == 0) begin
        report("unexpected index", 32'(got_idx), 0);
      end else begin
        want = pending_idx.pop_front();
        if (got_idx !== want.index) report("point_index", 32'(got_idx), 32'(want.index));
        if (got_last !== want.last) report("is_last", 32'(got_last), 32'(want.last));
      end
    endtask
  endclass

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 60;

  logic             clk_i;
  logic             rst_ni;
  logic             row_width_we_i;
  logic [CFG_W-1:0] row_width_i;
  logic             push;
  logic             full;
  coord_t           point_x_i, point_y_i, point_z_i;
  logic             start_of_cloud_i;
  logic             empty;
  logic             pop;
  idx_t             point_index_o;
  logic             is_last_o;

  index_board board;
  int         cycles;
  int         pop_hold;
  bit         calm;
  coord_t     gx, gy, gz;

  lidar_unreliable_point_filter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .row_width_we_i  (row_width_we_i),
    .row_width_i     (row_width_i),
    .push            (push),
    .full            (full),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .start_of_cloud_i(start_of_cloud_i),
    .empty           (empty),
    .pop             (pop),
    .point_index_o   (point_index_o),
    .is_last_o       (is_last_o)
  );

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Mostly short gaps, a few long ones, none during calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Run timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: check each popped beat, then, outside calm stretches, stall at random, now and then for long.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else begin
      if (pop && !empty) board.check_index(point_index_o, is_last_o);
      if (calm) begin
        pop <= 1'b1;
      end else if (pop_hold > 0) begin
        pop      <= 1'b0;
        pop_hold <= pop_hold - 1;
      end else if ($urandom_range(0, 99) < 2) begin
        pop      <= 1'b0;
        pop_hold <= $urandom_range(10, 40);
      end else begin
        pop <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Sends one point and records it once the beat is taken.
  task automatic send_point(coord_t x, coord_t y, coord_t z, logic sof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    start_of_cloud_i <= sof;
    do @(posedge clk_i); while (full);
    board.note_point(x, y, z, sof);
  endtask

  // Lets every expected index drain, then writes a new row width.
  task automatic set_width(logic [CFG_W-1:0] w);
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    row_width_we_i <= 1'b1;
    row_width_i <= w;
    @(posedge clk_i);
    row_width_we_i <= 1'b0;
    board.width_reg = 32'(w);
  endtask

  // Walks a surface with steps, depth jumps, zero points and random outliers.
  task automatic random_point();
    longint s;
    int mode;
    mode = $urandom_range(0, 11);
    case (mode)
      0, 1, 2, 3, 4: begin
        gx = coord_t'(gx + $signed($urandom_range(0, 400)) - 200);
        gy = coord_t'(gy + $signed($urandom_range(0, 4000)) - 2000);
      end
      5, 6: begin
        s = $urandom_range(0, 1) ? 21 : 19;
        gx = coord_t'(longint'(gx) * s / 20);
        gy = coord_t'(longint'(gy) * s / 20);
        gz = coord_t'(longint'(gz) * s / 20);
      end
      7: begin
        gx = coord_t'($urandom);
        gy = coord_t'($urandom);
        gz = coord_t'($urandom);
      end
      8: begin
        send_point('0, '0, '0, 1'b0);
        return;
      end
      9: begin
        gy = coord_t'(gy + $signed($urandom_range(0, 80000)) - 40000);
        gz = coord_t'(gz + $signed($urandom_range(0, 80000)) - 40000);
      end
      default: begin
        gx = coord_t'($urandom_range(200000, 1500000));
        gy = coord_t'($signed($urandom_range(0, 400000)) - 200000);
        gz = coord_t'($signed($urandom_range(0, 100000)) - 50000);
      end
    endcase
    send_point(gx, gy, gz, $urandom_range(0, 59) == 0);
  endtask

  initial begin
    logic [CFG_W-1:0] widths[6];
    board = new();
    cycles = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    row_width_we_i = 1'b0;
    row_width_i = '0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    start_of_cloud_i = 1'b0;
    gx = 24'sd655360;
    gy = 24'sd0;
    gz = 24'sd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a smooth start, then occlusions on both sides, zero and extreme points.
    send_point(24'sd655360, 24'sd0, 24'sd0, 1'b1);
    for (int k = 1; k < 7; k++) send_point(24'sd655360, 24'(k * 300), 24'sd0, 1'b0);
    send_point(24'sd688128, 24'sd2200, 24'sd0, 1'b0);
    send_point(24'sd622592, 24'sd2400, 24'sd0, 1'b0);
    send_point(24'sd655360, 24'sd2600, 24'sd0, 1'b0);
    send_point('0, '0, '0, 1'b0);
    send_point(24'sd655360, 24'sd2800, 24'sd0, 1'b0);
    send_point(24'sd8388607, -24'sd8388608, 24'sd8388607, 1'b0);
    send_point(-24'sd8388608, -24'sd8388608, -24'sd8388608, 1'b0);
    send_point(24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b0);
    send_point(24'sd655360, 24'sd60000, 24'sd0, 1'b0);
    send_point(24'sd655360, 24'sd3000, 24'sd0, 1'b0);
    send_point(24'sd655360, 24'sd60000, 24'sd0, 1'b0);
    send_point(24'sd655360, 24'sd3200, 24'sd0, 1'b1);

    // Zero width acts as one: no judging, and the row count wraps.
    set_width(13'd0);
    for (int k = 0; k < 70; k++) random_point();
    set_width(13'd1);
    for (int k = 0; k < 5; k++) random_point();

    // Random phases over narrow, odd and out-of-range widths.
    widths = '{13'd12, 13'd13, 13'd8191, 13'd17, 13'd4096, 13'd12};
    foreach (widths[p]) begin
      set_width(widths[p]);
      calm = (p == 2);
      send_point(gx, gy, gz, 1'b1);
      for (int k = 0; k < 18; k++) random_point();
    end

    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/lupf_pkg.sv
sv/lupf_front.sv
sv/lupf_arith.sv
sv/lupf_emit.sv
sv/lidar_unreliable_point_filter.sv
sim/lidar_unreliable_point_filter_test.sv
